>>> hdl/ilc_pkg.sv
// Package for the indexed list with cursor: sizes, operation and status codes,
// and the structs passed between the control and the cell row.
// No dependencies.
package ilc_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    // signed working width for resolving a position against the length
    localparam int RES_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        KIND_INSERT    = 3'd0,
        KIND_REMOVE    = 3'd1,
        KIND_GET       = 3'd2,
        KIND_CURRENT   = 3'd3,
        KIND_PEEK_PREV = 3'd4,
        KIND_PEEK_NEXT = 3'd5,
        KIND_MOVE      = 3'd6,
        KIND_FIND      = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        DIR_FIRST = 2'd0,
        DIR_LAST  = 2'd1,
        DIR_NEXT  = 2'd2,
        DIR_PREV  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_NONEIGH  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data_out;
        logic [IDX_W-1:0]  index_out;
        logic [CNT_W-1:0]  length;
        logic [IDX_W-1:0]  cursor_index;
        logic              cursor_valid;
        logic              at_start;
        logic              at_end;
    } result_t;

endpackage

>>> hdl/ilc_in_if.sv
// Request channel of the indexed list: valid/ready plus one operation.
// Depends on ilc_pkg.
interface ilc_in_if import ilc_pkg::*;;

    logic                    valid;
    logic                    ready;
    logic [2:0]              kind;
    logic signed [POS_W-1:0] position;
    logic [DATA_W-1:0]       value;
    logic [1:0]              direction;

    modport source (output valid, output kind, output position, output value,
                     output direction, input ready);
    modport sink   (input valid, input kind, input position, input value,
                     input direction, output ready);

endinterface

>>> hdl/ilc_out_if.sv
// Response channel of the indexed list: valid/ready plus one result.
// Depends on ilc_pkg.
interface ilc_out_if import ilc_pkg::*;;

    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [DATA_W-1:0] data_out;
    logic [IDX_W-1:0]  index_out;
    logic [CNT_W-1:0]  length;
    logic [IDX_W-1:0]  cursor_index;
    logic              cursor_valid;
    logic              at_start;
    logic              at_end;

    modport source (output valid, output status, output data_out, output index_out,
                     output length, output cursor_index, output cursor_valid,
                     output at_start, output at_end, input ready);
    modport sink   (input valid, input status, input data_out, input index_out,
                     input length, input cursor_index, input cursor_valid,
                     input at_start, input at_end, output ready);

endinterface

>>> hdl/indexed_list_with_cursor.sv
// Top level of the indexed list with cursor: cell row, control, response register.
// Depends on ilc_pkg, ilc_in_if, ilc_out_if, ilc_cell, ilc_ctrl.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  kind, position, value, direction
//   rsp      out  valid/ready  status, data_out, index_out, length,
//                              cursor_index, cursor_valid, at_start, at_end
//
// One operation per cycle: the whole step (position resolve, read mux, find
// priority encoder, shift of the cell row) settles in the accepting cycle and
// the result shows on rsp the cycle after.
// Reset clears length and cursor; the cell words stay unknown until written.
// req.ready drops only while a result waits and rsp.ready is low; a new
// request is taken in the same cycle the waiting result transfers.
module indexed_list_with_cursor
    import ilc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    ilc_in_if.sink   req,
    ilc_out_if.source rsp
);

    logic              accept;
    cell_cmd_t         cmd;
    result_t           result;
    logic [DATA_W-1:0] entry_data [CAPACITY];
    logic [CAPACITY-1:0] entry_match;

    logic              rsp_valid_reg;
    result_t           rsp_data_reg;

    // room when the output register is empty or drains this cycle
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    ilc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (req.kind),
        .position    (req.position),
        .value       (req.value),
        .direction   (req.direction),
        .entry_data  (entry_data),
        .entry_match (entry_match),
        .cmd         (cmd),
        .result      (result)
    );

    // row of slots; each one shifts from its left neighbor on insert and from
    // its right neighbor on remove, the ends see zero
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = entry_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = entry_data[g+1];
        end

        ilc_cell u_cell (
            .clk        (clk),
            .slot       (IDX_W'(g)),
            .cmd        (cmd),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (entry_data[g]),
            .match      (entry_match[g])
        );
    end

    // response register: valid is control, payload loads on each transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_data_reg.status;
    assign rsp.data_out     = rsp_data_reg.data_out;
    assign rsp.index_out    = rsp_data_reg.index_out;
    assign rsp.length       = rsp_data_reg.length;
    assign rsp.cursor_index = rsp_data_reg.cursor_index;
    assign rsp.cursor_valid = rsp_data_reg.cursor_valid;
    assign rsp.at_start     = rsp_data_reg.at_start;
    assign rsp.at_end       = rsp_data_reg.at_end;

endmodule

>>> hdl/ilc_cell.sv
// One list slot: holds a word, shifts from its neighbors on insert/remove,
// and compares its word against the broadcast value. Depends on ilc_pkg.
module ilc_cell
    import ilc_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  slot,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic              match
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (slot > cmd.index)
                begin
                    entry_next = left_data;
                end
                else if (slot == cmd.index)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_REMOVE:
            begin
                if (slot >= cmd.index)
                begin
                    entry_next = right_data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data  = entry_reg;
    assign match = (entry_reg == cmd.value);

endmodule

>>> hdl/ilc_ctrl.sv
// Control of the indexed list: resolves positions, holds length and cursor,
// drives the cell row and forms the result word. Depends on ilc_pkg.
module ilc_ctrl
    import ilc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [2:0]              kind,
    input  logic signed [POS_W-1:0] position,
    input  logic [DATA_W-1:0]       value,
    input  logic [1:0]              direction,
    input  logic [DATA_W-1:0]       entry_data [CAPACITY],
    input  logic [CAPACITY-1:0]     entry_match,
    output cell_cmd_t               cmd,
    output result_t                 result
);

    typedef struct packed {
        logic             bad;
        logic [IDX_W-1:0] index;
    } resolved_t;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic             cursor_set_reg, cursor_set_next;

    status_t          status;
    logic [IDX_W-1:0] index;
    logic             read_en;
    cell_op_t         op;
    logic [DATA_W-1:0] read_data;

    logic             cur_valid;
    logic [CNT_W-1:0] cursor_wide;
    logic [CNT_W-1:0] count_less;
    logic             find_hit;
    logic [IDX_W-1:0] find_index;
    logic             cv_after;
    logic [IDX_W-1:0] ci_after;

    // negative position counts from the end; out of range maps to slot 0
    function automatic resolved_t resolve(input logic signed [POS_W-1:0] p,
                                          input logic [CNT_W-1:0] limit);
        logic [RES_W-1:0] t;
        logic [RES_W-1:0] lim;
        resolved_t        r;
        lim = RES_W'(limit);
        t   = RES_W'(p) + (p[POS_W-1] ? lim : '0);
        r.bad   = t[RES_W-1] || (t >= lim);
        r.index = r.bad ? '0 : t[IDX_W-1:0];
        return r;
    endfunction

    assign cursor_wide = CNT_W'(cursor_reg);
    assign count_less  = count_reg - CNT_W'(1);
    assign cur_valid   = cursor_set_reg && (cursor_wide < count_reg);

    // lowest matching slot below the length
    always_comb
    begin
        find_hit   = 1'b0;
        find_index = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (entry_match[i] && (CNT_W'(i) < count_reg))
            begin
                find_hit   = 1'b1;
                find_index = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        resolved_t r;
        r               = '0;
        status          = ST_OK;
        index           = '0;
        read_en         = 1'b0;
        op              = CELL_HOLD;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        cursor_set_next = cursor_set_reg;
        case (kind_t'(kind))
            KIND_INSERT:
            begin
                if (count_reg >= CAP_COUNT)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    r               = resolve(position, count_reg + CNT_W'(1));
                    status          = r.bad ? ST_RANGE : ST_OK;
                    index           = r.index;
                    op              = CELL_INSERT;
                    count_next      = count_reg + CNT_W'(1);
                    cursor_next     = r.index;
                    cursor_set_next = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    r          = resolve(position, count_reg);
                    status     = r.bad ? ST_RANGE : ST_OK;
                    index      = r.index;
                    read_en    = 1'b1;
                    op         = CELL_REMOVE;
                    count_next = count_less;
                    if (cursor_set_reg)
                    begin
                        if (cursor_reg == r.index)
                        begin
                            if (CNT_W'(r.index) < count_less)
                            begin
                                cursor_next = r.index;
                            end
                            else if (count_less != '0)
                            begin
                                cursor_next = IDX_W'(count_less - CNT_W'(1));
                            end
                            else
                            begin
                                cursor_next     = '0;
                                cursor_set_next = 1'b0;
                            end
                        end
                        else if (cursor_reg > r.index)
                        begin
                            cursor_next = cursor_reg - IDX_W'(1);
                        end
                    end
                end
            end
            KIND_GET:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    r       = resolve(position, count_reg);
                    status  = r.bad ? ST_RANGE : ST_OK;
                    index   = r.index;
                    read_en = 1'b1;
                end
            end
            KIND_CURRENT:
            begin
                if (!cur_valid)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    index   = cursor_reg;
                    read_en = 1'b1;
                end
            end
            KIND_PEEK_PREV:
            begin
                if (!cur_valid)
                begin
                    status = ST_EMPTY;
                end
                else if (cursor_reg == '0)
                begin
                    status = ST_NONEIGH;
                end
                else
                begin
                    index   = cursor_reg - IDX_W'(1);
                    read_en = 1'b1;
                end
            end
            KIND_PEEK_NEXT:
            begin
                if (!cur_valid)
                begin
                    status = ST_EMPTY;
                end
                else if (cursor_wide + CNT_W'(1) >= count_reg)
                begin
                    status = ST_NONEIGH;
                end
                else
                begin
                    index   = cursor_reg + IDX_W'(1);
                    read_en = 1'b1;
                end
            end
            KIND_MOVE:
            begin
                if ((count_reg == '0) || (direction[1] && !cur_valid))
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    case (dir_t'(direction))
                        DIR_FIRST:
                        begin
                            index = '0;
                        end
                        DIR_LAST:
                        begin
                            index = IDX_W'(count_less);
                        end
                        DIR_NEXT:
                        begin
                            if (cursor_wide + CNT_W'(1) >= count_reg)
                            begin
                                status = ST_NONEIGH;
                            end
                            else
                            begin
                                index = cursor_reg + IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            if (cursor_reg == '0)
                            begin
                                status = ST_NONEIGH;
                            end
                            else
                            begin
                                index = cursor_reg - IDX_W'(1);
                            end
                        end
                    endcase
                    if (status == ST_OK)
                    begin
                        cursor_next     = index;
                        cursor_set_next = 1'b1;
                    end
                end
            end
            default:
            begin
                status = find_hit ? ST_OK : ST_NOTFOUND;
                index  = find_index;
            end
        endcase
    end

    assign read_data = read_en ? entry_data[index] : '0;

    always_comb
    begin
        cmd.op    = accept ? op : CELL_HOLD;
        cmd.index = index;
        cmd.value = value;
    end

    assign cv_after = cursor_set_next && (CNT_W'(cursor_next) < count_next);
    assign ci_after = cv_after ? cursor_next : '0;

    always_comb
    begin
        result.status       = status;
        result.data_out     = read_data;
        result.index_out    = index;
        result.length       = count_next;
        result.cursor_index = ci_after;
        result.cursor_valid = cv_after;
        result.at_start     = cv_after && (ci_after == '0);
        result.at_end       = cv_after && (CNT_W'(ci_after) + CNT_W'(1) == count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cursor_reg     <= '0;
            cursor_set_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            cursor_set_reg <= cursor_set_next;
        end
    end

endmodule

>>> sim/indexed_list_with_cursor_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_list_with_cursor: a directed table, then random traffic.
// Depends on ilc_pkg, ilc_in_if, ilc_out_if and the block itself.
module indexed_list_with_cursor_tb;
    import ilc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int ITEMS_PER_PASS = 260;
    localparam int MODE_RUN       = 40;    // items before the random mix changes
    localparam int HOLD_CYCLES    = 40;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 8;     // result shows the cycle after the transfer
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    ilc_in_if  req_if ();
    ilc_out_if rsp_if ();

    indexed_list_with_cursor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // one row of the directed table; fixed rows carry a typed-in result
    typedef struct {
        kind_t                   kind;
        logic signed [POS_W-1:0] position;
        logic [DATA_W-1:0]       value;
        dir_t                    direction;
        bit                      fixed;
        result_t                 result;
    } list_row_t;

    // shadow copy of the list, updated at every accepted request
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len;
    int                cur_pos;
    bit                cur_on;

    result_t   list_expect_q [$];
    list_row_t directed_rows [$];

    int err_count;
    int req_count;
    int rsp_count;
    int status_seen [6];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_reqs;       // bumped by the stimulus, consumed by the receiver

    // Signed position against a limit: count+1 for insert, count otherwise.
    // Out of range flags bad and falls back to index 0.
    function automatic int resolve_pos(input logic signed [POS_W-1:0] p, input int lim,
                                       output bit bad);
        int t;
        t = (p >= 0) ? int'(p) : int'(p) + lim;
        bad = !(t >= 0 && t < lim);
        return bad ? 0 : t;
    endfunction

    // Apply one operation to the shadow list and return the result it must produce.
    function automatic result_t predict_list_step(input kind_t k,
                                                  input logic signed [POS_W-1:0] p,
                                                  input logic [DATA_W-1:0] v, input dir_t d);
        result_t r;
        int      at;
        bit      bad;
        bit      live;
        r        = '0;
        r.status = ST_OK;
        at       = 0;
        bad      = 1'b0;
        live     = cur_on && cur_pos < list_len;
        case (k)
            KIND_INSERT:
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else
                begin
                    at = resolve_pos(p, list_len + 1, bad);
                    if (bad) r.status = ST_RANGE;
                    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
                    list_mem[at] = v;
                    list_len++;
                    cur_pos = at;
                    cur_on  = 1'b1;
                end
            KIND_REMOVE:
                if (list_len == 0) r.status = ST_EMPTY;
                else
                begin
                    at = resolve_pos(p, list_len, bad);
                    if (bad) r.status = ST_RANGE;
                    r.data_out = list_mem[at];
                    for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                    // cursor on the removed item goes to its successor or the new tail
                    if (cur_on)
                    begin
                        if (cur_pos == at)
                        begin
                            if (at < list_len) cur_pos = at;
                            else if (list_len > 0) cur_pos = list_len - 1;
                            else
                            begin
                                cur_pos = 0;
                                cur_on  = 1'b0;
                            end
                        end
                        else if (cur_pos > at) cur_pos--;
                    end
                end
            KIND_GET:
                if (list_len == 0) r.status = ST_EMPTY;
                else
                begin
                    at = resolve_pos(p, list_len, bad);
                    if (bad) r.status = ST_RANGE;
                    r.data_out = list_mem[at];
                end
            KIND_CURRENT:
                if (!live) r.status = ST_EMPTY;
                else
                begin
                    at         = cur_pos;
                    r.data_out = list_mem[at];
                end
            KIND_PEEK_PREV:
                if (!live) r.status = ST_EMPTY;
                else if (cur_pos == 0) r.status = ST_NONEIGH;
                else
                begin
                    at         = cur_pos - 1;
                    r.data_out = list_mem[at];
                end
            KIND_PEEK_NEXT:
                if (!live) r.status = ST_EMPTY;
                else if (cur_pos + 1 >= list_len) r.status = ST_NONEIGH;
                else
                begin
                    at         = cur_pos + 1;
                    r.data_out = list_mem[at];
                end
            KIND_MOVE:
                if (list_len == 0 || ((d == DIR_NEXT || d == DIR_PREV) && !live))
                    r.status = ST_EMPTY;
                else
                begin
                    case (d)
                        DIR_FIRST: at = 0;
                        DIR_LAST:  at = list_len - 1;
                        DIR_NEXT:
                            if (cur_pos + 1 >= list_len) r.status = ST_NONEIGH;
                            else at = cur_pos + 1;
                        default:
                            if (cur_pos == 0) r.status = ST_NONEIGH;
                            else at = cur_pos - 1;
                    endcase
                    if (r.status == ST_OK)
                    begin
                        cur_pos = at;
                        cur_on  = 1'b1;
                    end
                end
            default:
            begin
                // lowest matching index wins
                r.status = ST_NOTFOUND;
                for (int i = 0; i < list_len; i++)
                    if (r.status == ST_NOTFOUND && list_mem[i] == v)
                    begin
                        r.status = ST_OK;
                        at       = i;
                    end
            end
        endcase
        live           = cur_on && cur_pos < list_len;
        r.index_out    = at[IDX_W-1:0];
        r.length       = list_len[CNT_W-1:0];
        r.cursor_index = live ? cur_pos[IDX_W-1:0] : '0;
        r.cursor_valid = live;
        r.at_start     = live && cur_pos == 0;
        r.at_end       = live && cur_pos + 1 == list_len;
        return r;
    endfunction

    task automatic add_row(input kind_t k, input int p, input logic [DATA_W-1:0] v,
                           input dir_t d, input bit fixed, input result_t res);
        list_row_t row;
        row.kind      = k;
        row.position  = p[POS_W-1:0];
        row.value     = v;
        row.direction = d;
        row.fixed     = fixed;
        row.result    = res;
        directed_rows.push_back(row);
    endtask

    // Offer one request after a random gap, wait for its transfer, then record
    // what it must return. Fixed rows still run through the shadow list.
    task automatic drive_list_op(input kind_t k, input logic signed [POS_W-1:0] p,
                                 input logic [DATA_W-1:0] v, input dir_t d,
                                 input bit fixed, input result_t res);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.kind      <= k;
        req_if.position  <= p;
        req_if.value     <= v;
        req_if.direction <= d;
        do @(posedge clk); while (!req_if.ready);
        predicted = predict_list_step(k, p, v, d);
        if (fixed) predicted = res;
        status_seen[predicted.status]++;
        req_count++;
        list_expect_q.push_back(predicted);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Response side: every transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            rsp_count++;
            if (list_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0h data %0h",
                         $time, rsp_if.status, rsp_if.data_out);
                err_count++;
            end
            else
            begin
                want = list_expect_q.pop_front();
                check_field("status",       want.status,       rsp_if.status);
                check_field("data_out",     want.data_out,     rsp_if.data_out);
                check_field("index_out",    want.index_out,    rsp_if.index_out);
                check_field("length",       want.length,       rsp_if.length);
                check_field("cursor_index", want.cursor_index, rsp_if.cursor_index);
                check_field("cursor_valid", want.cursor_valid, rsp_if.cursor_valid);
                check_field("at_start",     want.at_start,     rsp_if.at_start);
                check_field("at_end",       want.at_end,       rsp_if.at_end);
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off when asked for one.
    initial
    begin : rsp_sink
        int hold_left;
        int hold_taken;
        hold_left    = 0;
        hold_taken   = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_taken != hold_reqs)
            begin
                hold_taken = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without a transfer on either channel means a hang.
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (rst_n !== 1'b1) quiet = 0;
        else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet, list_expect_q.size());
                $display("[indexed_list_with_cursor] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        kind_t                   k;
        dir_t                    d;
        logic signed [POS_W-1:0] p;
        logic [DATA_W-1:0]       v;
        int                      pick;
        int                      lim;
        int                      ins_pct;
        int                      rem_pct;

        err_count     = 0;
        req_count     = 0;
        rsp_count     = 0;
        hold_reqs     = 0;
        send_idle_pct = 7;
        recv_idle_pct = 50;
        foreach (status_seen[i]) status_seen[i] = 0;
        list_len = 0;
        cur_pos  = 0;
        cur_on   = 1'b0;

        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.kind      <= KIND_INSERT;
        req_if.position  <= '0;
        req_if.value     <= '0;
        req_if.direction <= DIR_FIRST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Empty-list refusals, the first insert and the out-of-range insert
        // are typed in; the rest is left to the shadow list.
        add_row(KIND_REMOVE,    0,  '0, DIR_FIRST, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_GET,       -1, '0, DIR_FIRST, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_CURRENT,   0,  '0, DIR_FIRST, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_PEEK_PREV, 0,  '0, DIR_FIRST, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_PEEK_NEXT, 0,  '0, DIR_FIRST, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_MOVE,      0,  '0, DIR_FIRST, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_MOVE,      0,  '0, DIR_NEXT,  1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_FIND,      0,  '0, DIR_FIRST, 1, '{ST_NOTFOUND, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_INSERT, 0, 32'hFFFF_FFFF, DIR_FIRST, 1, '{ST_OK, 0, 0, 1, 0, 1, 1, 1});
        add_row(KIND_INSERT, -1, 32'h0, DIR_LAST, 0, '0);                 // append
        // past the end: flagged, lands at index 0
        add_row(KIND_INSERT, 16, 32'hA5A5_A5A5, DIR_FIRST, 1, '{ST_RANGE, 0, 0, 3, 0, 1, 1, 0});
        add_row(KIND_INSERT, -17, 32'h5A5A_5A5A, DIR_PREV, 0, '0);
        add_row(KIND_GET,       -1,  '0, DIR_FIRST, 0, '0);
        add_row(KIND_GET,       16,  '0, DIR_FIRST, 0, '0);
        add_row(KIND_GET,       -17, '0, DIR_FIRST, 0, '0);
        add_row(KIND_MOVE,      0,   '0, DIR_LAST,  0, '0);
        add_row(KIND_PEEK_NEXT, 0,   '0, DIR_FIRST, 0, '0);               // no neighbour
        add_row(KIND_MOVE,      0,   '0, DIR_NEXT,  0, '0);               // no neighbour
        add_row(KIND_MOVE,      0,   '0, DIR_PREV,  0, '0);
        add_row(KIND_PEEK_PREV, 0,   '0, DIR_FIRST, 0, '0);
        add_row(KIND_CURRENT,   0,   '0, DIR_FIRST, 0, '0);
        add_row(KIND_MOVE,      0,   '0, DIR_FIRST, 0, '0);
        add_row(KIND_MOVE,      0,   '0, DIR_PREV,  0, '0);               // no neighbour
        add_row(KIND_FIND,      0,   32'hFFFF_FFFF, DIR_FIRST, 0, '0);
        add_row(KIND_FIND,      0,   32'h1234_5678, DIR_FIRST, 0, '0);    // not found
        add_row(KIND_REMOVE,    0,   '0, DIR_FIRST, 0, '0);               // cursor item goes
        add_row(KIND_REMOVE,    -1,  '0, DIR_FIRST, 0, '0);
        foreach (directed_rows[i])
            drive_list_op(directed_rows[i].kind, directed_rows[i].position,
                          directed_rows[i].value, directed_rows[i].direction,
                          directed_rows[i].fixed, directed_rows[i].result);

        // Random part, three passes: sender idles lightly and receiver heavily,
        // then swapped, then no idling with one long receiver hold-off up front.
        for (int pass = 0; pass < 3; pass++)
        begin
            send_idle_pct = (pass == 0) ? 7 : (pass == 1) ? 50 : 0;
            recv_idle_pct = (pass == 0) ? 50 : (pass == 1) ? 7 : 0;
            if (pass == 2) hold_reqs++;
            for (int n = 0; n < ITEMS_PER_PASS; n++)
            begin
                // fill / drain / mixed runs so the list hits full and empty often
                case ((n / MODE_RUN) % 3)
                    0:       begin ins_pct = 60; rem_pct = 10; end
                    1:       begin ins_pct = 10; rem_pct = 60; end
                    default: begin ins_pct = 25; rem_pct = 20; end
                endcase
                pick = $urandom_range(99);
                if (pick < ins_pct) k = KIND_INSERT;
                else if (pick < ins_pct + rem_pct) k = KIND_REMOVE;
                else k = kind_t'($urandom_range(int'(KIND_GET), int'(KIND_FIND)));

                // mostly a legal index, from either end; now and then anything
                lim = (k == KIND_INSERT) ? list_len + 1 : list_len;
                if ($urandom_range(3) == 0 || lim == 0) pick = int'($urandom_range(33)) - 17;
                else
                begin
                    pick = $urandom_range(lim - 1);
                    if ($urandom_range(1)) pick = pick - lim;
                end
                p = pick[POS_W-1:0];

                // values: random, a small pool, a copy of a stored word, or an extreme
                case ($urandom_range(3))
                    0: v = $urandom;
                    1: v = $urandom_range(3);
                    2: v = (list_len > 0) ? list_mem[$urandom_range(list_len - 1)] : $urandom;
                    default: v = $urandom_range(1) ? '1 : '0;
                endcase
                d = dir_t'($urandom_range(3));
                drive_list_op(k, p, v, d, 1'b0, '0);
            end
        end

        req_if.valid <= 1'b0;
        while (list_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests %0d, results %0d, mismatches %0d", req_count, rsp_count, err_count);
        $display("status mix ok/range/empty/full/notfound/noneighbour: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_NOTFOUND], status_seen[ST_NONEIGH]);
        if (err_count == 0)
            $display("[indexed_list_with_cursor] OK");
        else
            $display("[indexed_list_with_cursor] ERROR");
        $finish;
    end

endmodule
